FILE: rtl/core/smpe_pkg.sv
// smpe_pkg: shared constants, register indexes and types of the start-marker
// payload extractor. No dependencies; used by smpe_core and the top level.
`default_nettype none

package smpe_pkg;

  // default marker length in bytes
  localparam int unsigned MARKER_BYTES_DEF = 5;
  // upper clamp for the configured payload length
  localparam int unsigned PAYLOAD_MAX      = 32;

  // field and register widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned MARKER_W = 40;
  localparam int unsigned LENGTH_W = 6;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // length compare width, one bit above the count
  localparam int unsigned LEN_CMP_W = COUNT_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_VALUE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 1'd1;

  // register reset values
  localparam logic [MARKER_W-1:0] MARKER_RESET = '0;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 6'd8;

  // one extracted payload item
  typedef struct packed {
    logic               last_of_packet;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  payload_byte;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/smpe_core.sv
// smpe_core: marker hunting window and payload counter of the extractor.
// Depends on smpe_pkg; updates its state on every accepted item.
`default_nettype none

module smpe_core #(
  parameter int unsigned MARKER_BYTES = smpe_pkg::MARKER_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [smpe_pkg::BYTE_W-1:0]     rx_byte_i,
  input  wire logic [smpe_pkg::MARKER_W-1:0]   marker_value_i,
  input  wire logic [smpe_pkg::LENGTH_W-1:0]   payload_length_i,
  output logic                                 res_valid_o,
  output smpe_pkg::result_t                    res_o
);

  localparam int unsigned WIN_W  = MARKER_BYTES * smpe_pkg::BYTE_W;
  localparam int unsigned FILL_W = $clog2(MARKER_BYTES + 1);
  localparam int unsigned EXT_W  = (WIN_W > smpe_pkg::MARKER_W) ? WIN_W : smpe_pkg::MARKER_W;
  localparam int unsigned LCW    = smpe_pkg::LEN_CMP_W;

  logic [WIN_W-1:0]             window_q, window_d;
  logic [FILL_W-1:0]            fill_q, fill_d;
  logic [smpe_pkg::COUNT_W-1:0] count_q, count_d;
  logic                         in_payload_q, in_payload_d;

  logic [WIN_W+smpe_pkg::BYTE_W-1:0] win_cat;
  logic [WIN_W-1:0]                  win_shift;
  logic [EXT_W-1:0]                  marker_ext;
  logic [WIN_W-1:0]                  marker_cmp;
  logic [FILL_W-1:0]                 fill_next;
  logic                              match;
  logic [LCW-1:0]                    len_ext, eff_len, cnt_inc;
  logic                              last;

  // shift the new byte into the window, oldest byte drops out on top
  assign win_cat    = {window_q, rx_byte_i};
  assign win_shift  = win_cat[WIN_W-1:0];
  assign marker_ext = EXT_W'(marker_value_i);
  assign marker_cmp = marker_ext[WIN_W-1:0];
  assign fill_next  = (fill_q < FILL_W'(MARKER_BYTES)) ? fill_q + FILL_W'(1) : fill_q;
  assign match      = (fill_next == FILL_W'(MARKER_BYTES)) && (win_shift == marker_cmp);

  // effective payload length, clamped to one and to the maximum
  always_comb begin
    len_ext = LCW'(payload_length_i);
    if (len_ext == '0) begin
      eff_len = LCW'(1);
    end else if (len_ext > LCW'(smpe_pkg::PAYLOAD_MAX)) begin
      eff_len = LCW'(smpe_pkg::PAYLOAD_MAX);
    end else begin
      eff_len = len_ext;
    end
  end

  assign cnt_inc = LCW'(count_q) + LCW'(1);
  assign last    = (cnt_inc >= eff_len);

  // result of the current item
  assign res_valid_o         = accept_i && in_payload_q;
  assign res_o.payload_byte   = rx_byte_i;
  assign res_o.byte_index     = count_q[smpe_pkg::INDEX_W-1:0];
  assign res_o.last_of_packet = last;

  // next state
  always_comb begin
    window_d     = window_q;
    fill_d       = fill_q;
    count_d      = count_q;
    in_payload_d = in_payload_q;
    if (accept_i) begin
      if (in_payload_q) begin
        if (last) begin
          in_payload_d = 1'b0;
          count_d      = '0;
          window_d     = '0;
          fill_d       = '0;
        end else begin
          count_d = cnt_inc[smpe_pkg::COUNT_W-1:0];
        end
      end else if (match) begin
        in_payload_d = 1'b1;
        count_d      = '0;
        window_d     = '0;
        fill_d       = '0;
      end else begin
        window_d = win_shift;
        fill_d   = fill_next;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      fill_q       <= '0;
      count_q      <= '0;
      in_payload_q <= 1'b0;
    end else begin
      window_q     <= window_d;
      fill_q       <= fill_d;
      count_q      <= count_d;
      in_payload_q <= in_payload_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sync_marker_payload_extractor_unit.sv
// sync_marker_payload_extractor_unit: top level of the start-marker payload
// extractor. Depends on smpe_pkg and smpe_core.
//
// Usage:
//   s_axis carries one received byte per item in tdata. While hunting, the
//   last MARKER_BYTES bytes are compared with the marker register; the byte
//   that completes a match yields no output. The next payload_length bytes
//   (clamped to 1..32) then leave on m_axis, each with its payload index and tlast on
//   the final one, after which hunting starts again with an empty window.
//   Configuration: cfg_we_i writes cfg_data_i to the register cfg_idx_i
//   (0 marker value, 1 payload length); write only while the block is idle.
//   Output: a payload item appears on m_axis in the cycle after it is taken.
//   Throughput: one item per cycle unless m_axis stalls; the marker compare and length check sit
//   in a single stage in front of the output register.
//   Reset: hunting, empty window, marker 0, payload length 8, no output.
//   Stall: while m_axis_tready is low and an item is held, the output register
//   keeps it and s_axis_tready drops, so no item is taken until the slot frees.
`default_nettype none

module sync_marker_payload_extractor_unit #(
  parameter int unsigned MARKER_BYTES = smpe_pkg::MARKER_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [15:0]                            m_axis_tdata,  // [7:0] payload_byte,
                                                                // [12:8] byte_index
  output logic                                   m_axis_tlast,  // last_of_packet
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [smpe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [smpe_pkg::MARKER_W-1:0]     cfg_data_i
);

  logic [smpe_pkg::MARKER_W-1:0] marker_q;
  logic [smpe_pkg::LENGTH_W-1:0] length_q;
  logic                          accept;
  logic                          res_valid;
  smpe_pkg::result_t             res;
  logic                          out_valid_q;
  smpe_pkg::result_t             out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= smpe_pkg::MARKER_RESET;
      length_q <= smpe_pkg::LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smpe_pkg::CFG_MARKER_VALUE:   marker_q <= cfg_data_i;
        smpe_pkg::CFG_PAYLOAD_LENGTH: length_q <= cfg_data_i[smpe_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // take an item whenever the output slot is free or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  smpe_core #(
    .MARKER_BYTES (MARKER_BYTES)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .rx_byte_i        (s_axis_tdata),
    .marker_value_i   (marker_q),
    .payload_length_i (length_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.byte_index, out_q.payload_byte};
  assign m_axis_tlast  = out_q.last_of_packet;

endmodule

`default_nettype wire
